### rtl/core/iirbq_pkg.sv
// Shared types and constants for the second-order direct form II IIR filter.
// No dependencies; used by iirbq_ctrl, iirbq_datapath and the top level.
`default_nettype none

package iirbq_pkg;

  // Fixed field widths of the sample channels and the internal data path.
  localparam int SAMPLE_IN_W  = 10;
  localparam int DATA_W       = 16;

  // Defaults for the top-level parameters.
  localparam int FILTER_ORDER_DEF = 2;
  localparam int COEF_BITS_DEF    = 10;

  // Only the first two taps carry programmable coefficients.
  localparam int NUM_COEF_TAPS = 2;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_B0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_B1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_B2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_A1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COEF_A2 = 3'd4;

  // Coefficient values after reset.
  localparam int COEF_B0_RST = 52;
  localparam int COEF_B1_RST = 105;
  localparam int COEF_B2_RST = 52;
  localparam int COEF_A1_RST = 95;
  localparam int COEF_A2_RST = -50;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_x;   // capture the accepted sample
    logic clr_acc;  // clear both tap sums
    logic mul_en;   // register a new product
    logic mul_w;    // product is w times b0 instead of a tap product
    logic mul_tap;  // tap of the product (0 or 1)
    logic mul_ff;   // tap product uses the feed-forward coefficient
    logic acc_en;   // add the registered product into its sum
    logic w_en;     // form the new intermediate w
    logic y_en;     // form the output, load the output register, shift the delay line
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/iir_biquad_direct_form_two.sv
// Each sample runs these steps in order: the accepting step, the tap products, a drain,
// w, the b0 product and the output step, which waits while a held result is not taken.
// A new sample is accepted only once the previous one has left the output step.
// Reset (rst_n low, synchronous): delay line cleared, coefficients set to their
// defaults, output register empty.
`default_nettype none

// Top level of the second-order direct form II IIR filter.
//
// Each sample walks through one 16 x COEF_BITS multiplier. The controller
// issues the feedback and feed-forward tap products first, alternating a and b
// coefficients per tap; each product is registered, shifted right arithmetically
// by COEF_BITS-1 and added into its 16-bit sum in the following cycle. Then the
// new intermediate w is formed as the sample shifted right by COEF_BITS-9 plus
// the feedback sum, w is multiplied by b0, and the output is that shifted
// product plus the feed-forward sum. All sums wrap at 16 bits.
//
// The output register parts the two channels: a new sample can be accepted
// while the previous result still waits for its transfer. The sequencer only
// stalls at its final step when the held result has not yet been taken.
// Configuration writes are expected only while the filter is idle.
module iir_biquad_direct_form_two #(
  parameter int FILTER_ORDER = iirbq_pkg::FILTER_ORDER_DEF,
  parameter int COEF_BITS    = iirbq_pkg::COEF_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  // input sample channel
  input  wire logic                                     in_valid,
  output logic                                          in_stall,
  input  wire logic signed [iirbq_pkg::SAMPLE_IN_W-1:0] in_sample_in,
  // result channel
  output logic                                          out_valid,
  input  wire logic                                     out_stall,
  output logic signed [iirbq_pkg::DATA_W-1:0]           out_sample_out,
  // configuration write port
  input  wire logic                                     cfg_wr_en,
  input  wire logic [iirbq_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  wire logic [COEF_BITS-1:0]                     cfg_wdata
);

  iirbq_pkg::cmd_t cmd;

  iirbq_ctrl #(
    .FILTER_ORDER(FILTER_ORDER)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  iirbq_datapath #(
    .FILTER_ORDER(FILTER_ORDER),
    .COEF_BITS   (COEF_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_sample_in  (in_sample_in),
    .out_sample_out(out_sample_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

endmodule

`default_nettype wire

### rtl/core/iirbq_ctrl.sv
// Sequencer of the biquad: walks the shared multiplier through the taps,
// w and b0, and owns both handshakes. Depends on iirbq_pkg.
`default_nettype none

module iirbq_ctrl #(
  parameter int FILTER_ORDER = iirbq_pkg::FILTER_ORDER_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output iirbq_pkg::cmd_t    cmd
);

  localparam int CoefTaps = (FILTER_ORDER < iirbq_pkg::NUM_COEF_TAPS) ?
                            FILTER_ORDER : iirbq_pkg::NUM_COEF_TAPS;
  localparam int NumMul   = 2 * CoefTaps;
  localparam int KW       = $clog2(NumMul);
  localparam logic [KW-1:0] KLast = KW'(NumMul - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_WCALC = 3'd3;
  localparam logic [2:0] S_MB0   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          in_xfer;
  logic          slot_free;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.mul_tap   = (CoefTaps > 1) ? k_r[KW-1] : 1'b0;
    cmd.mul_ff    = k_r[0];
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load_x  = 1'b1;
          cmd.clr_acc = 1'b1;
          k_nxt       = '0;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        cmd.acc_en = (k_r != '0);
        if (k_r == KLast) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + KW'(1);
        end
      end
      S_DRAIN: begin
        cmd.acc_en = 1'b1;
        state_nxt  = S_WCALC;
      end
      S_WCALC: begin
        cmd.w_en  = 1'b1;
        state_nxt = S_MB0;
      end
      S_MB0: begin
        cmd.mul_en = 1'b1;
        cmd.mul_w  = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd.y_en      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  // An accepted sample always starts the tap walk at the first product.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_MUL) && (k_r == '0))
    else $error("tap walk did not start after an input transfer");

  // A held result is never overwritten by a new one.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.y_en |-> !(out_valid_r && out_stall))
    else $error("output register overwritten while stalled");

  // Every accumulation consumes a product registered in the cycle before.
  a_acc_has_prod: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc_en |-> $past(cmd.mul_en))
    else $error("accumulation without a fresh product");

  // A result appears only when the output step has run.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.y_en))
    else $error("output valid rose without an output step");
`endif

endmodule

`default_nettype wire

### rtl/core/iirbq_datapath.sv
// Datapath of the biquad: coefficient registers, delay line, one shared
// multiplier with a product register, tap sums and the output register.
// Depends on iirbq_pkg.
`default_nettype none

module iirbq_datapath #(
  parameter int FILTER_ORDER = iirbq_pkg::FILTER_ORDER_DEF,
  parameter int COEF_BITS    = iirbq_pkg::COEF_BITS_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire iirbq_pkg::cmd_t                         cmd,
  input  wire logic signed [iirbq_pkg::SAMPLE_IN_W-1:0] in_sample_in,
  output logic signed [iirbq_pkg::DATA_W-1:0]          out_sample_out,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [iirbq_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [COEF_BITS-1:0]                    cfg_wdata
);

  localparam int DW       = iirbq_pkg::DATA_W;
  localparam int NT       = iirbq_pkg::NUM_COEF_TAPS;
  localparam int PW       = DW + COEF_BITS;
  localparam int XShift   = COEF_BITS - 9;
  localparam int CoefTaps = (FILTER_ORDER < NT) ? FILTER_ORDER : NT;

  logic signed [COEF_BITS-1:0] b0_r;
  logic signed [COEF_BITS-1:0] ff_coef_r [NT];
  logic signed [COEF_BITS-1:0] fb_coef_r [NT];
  logic signed [DW-1:0]        delay_r   [FILTER_ORDER];

  logic signed [iirbq_pkg::SAMPLE_IN_W-1:0] x_r;
  logic signed [PW-1:0]        prod_r, prod_nxt;
  logic                        prod_ff_r;
  logic signed [DW-1:0]        fb_r, ff_r, w_r, y_r;

  logic signed [DW-1:0]        tap_val;
  logic signed [DW-1:0]        mul_a;
  logic signed [COEF_BITS-1:0] mul_b;
  logic signed [DW-1:0]        prod_sh;
  logic signed [DW-1:0]        x_ext;

  // Tap operand: the second tap exists only for orders of two and above.
  assign tap_val = (CoefTaps > 1 && cmd.mul_tap) ? delay_r[CoefTaps-1] : delay_r[0];
  assign mul_a   = cmd.mul_w ? w_r : tap_val;
  assign mul_b   = cmd.mul_w ? b0_r :
                   (cmd.mul_ff ? ff_coef_r[cmd.mul_tap] : fb_coef_r[cmd.mul_tap]);
  assign prod_nxt = mul_a * mul_b;

  // Arithmetic shift by COEF_BITS-1, then wrap to 16 bits.
  assign prod_sh = $signed(prod_r[COEF_BITS+DW-2:COEF_BITS-1]);
  assign x_ext   = DW'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r         <= COEF_BITS'(iirbq_pkg::COEF_B0_RST);
      ff_coef_r[0] <= COEF_BITS'(iirbq_pkg::COEF_B1_RST);
      ff_coef_r[1] <= COEF_BITS'(iirbq_pkg::COEF_B2_RST);
      fb_coef_r[0] <= COEF_BITS'(iirbq_pkg::COEF_A1_RST);
      fb_coef_r[1] <= COEF_BITS'(iirbq_pkg::COEF_A2_RST);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        iirbq_pkg::REG_COEF_B0: b0_r         <= $signed(cfg_wdata);
        iirbq_pkg::REG_COEF_B1: ff_coef_r[0] <= $signed(cfg_wdata);
        iirbq_pkg::REG_COEF_B2: ff_coef_r[1] <= $signed(cfg_wdata);
        iirbq_pkg::REG_COEF_A1: fb_coef_r[0] <= $signed(cfg_wdata);
        iirbq_pkg::REG_COEF_A2: fb_coef_r[1] <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FILTER_ORDER; i++) begin
        delay_r[i] <= '0;
      end
    end else if (cmd.y_en) begin
      for (int i = FILTER_ORDER - 1; i > 0; i--) begin
        delay_r[i] <= delay_r[i-1];
      end
      delay_r[0] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_x) begin
      x_r <= in_sample_in;
    end
    if (cmd.mul_en) begin
      prod_r    <= prod_nxt;
      prod_ff_r <= cmd.mul_ff;
    end
    if (cmd.clr_acc) begin
      fb_r <= '0;
      ff_r <= '0;
    end else if (cmd.acc_en) begin
      if (prod_ff_r) begin
        ff_r <= ff_r + prod_sh;
      end else begin
        fb_r <= fb_r + prod_sh;
      end
    end
    if (cmd.w_en) begin
      w_r <= (x_ext >>> XShift) + fb_r;
    end
    if (cmd.y_en) begin
      y_r <= prod_sh + ff_r;
    end
  end

  assign out_sample_out = y_r;

endmodule

`default_nettype wire
